>>> rtl/pvsm_pkg.sv
// shared types, constants and the sine table function of the stereo mixdown block
package pvsm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_W      = 24;
  localparam int OUT_DATA_W = 48;
  localparam int ACC_W      = 40;
  localparam int GAIN_W     = 12;
  localparam int ANG_W      = 12;
  localparam int ANG_FRAC_W = 11;
  localparam int ROM_W      = 16;

  localparam int MC_W = 41;
  localparam int MQ_W = 16;
  localparam int PR_W = MC_W + MQ_W;

  localparam int DIV_W = 17;
  localparam int DVR_W = 5;

  localparam int GAIN_DIV  = 20;
  localparam int GAIN_PRE  = 32810;
  localparam int GAIN_POST = 1640;
  localparam int PAN_DIV   = 10;
  localparam int PAN_PRE   = 32805;
  localparam int PAN_POST  = 3280;
  localparam int GAIN_MAX  = 2048;
  localparam int PAN_LIM   = 1024;
  localparam int ANG_FULL  = 2048;
  localparam int MONO_GAIN = 23170;
  localparam int OUT_MAX   = 8388607;
  localparam int OUT_MIN   = -8388608;

  localparam longint ACC_MAX     = 64'sd549755813887;
  localparam longint ACC_MIN     = -ACC_MAX - 64'sd1;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic [1:0] REG_LEVEL_A = 2'd0;
  localparam logic [1:0] REG_LEVEL_B = 2'd1;
  localparam logic [1:0] REG_PAN     = 2'd2;
  localparam logic [1:0] REG_MODE    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_WAIT,
    S_RD_LO,
    S_RD_HI,
    S_RD_LAST,
    S_MGO,
    S_MWAIT,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    M_INTERP,
    M_GAIN_A,
    M_GAIN_B,
    M_COS,
    M_SIN,
    M_FOLD
  } mstep_t;

  // taylor series of the sine, angle in q30 radians, result q1.15
  function automatic logic [ROM_W-1:0] sine_q15(input longint x);
    longint x2;
    longint term;
    longint sum;
    longint q;
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    term = ((term * x2) >>> 30) / 6;
    sum = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32768) begin
      q = 64'sd32768;
    end
    return ROM_W'(q);
  endfunction

endpackage

>>> rtl/pvsm_cvdiv.sv
// restoring divider by a small constant, one quotient bit per cycle
module pvsm_cvdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pvsm_pkg::DIV_W-1:0]  dividend,
  input  logic [pvsm_pkg::DVR_W-1:0]  divisor,
  output logic                        done,
  output logic [pvsm_pkg::DIV_W-1:0]  quotient
);
  import pvsm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dv;
  logic [DVR_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVR_W:0]   trial;
  logic             qbit;
  logic [DVR_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dv[DIV_W-1]};
    qbit = (trial >= {1'b0, divisor});
    rem_next = qbit ? DVR_W'(trial - {1'b0, divisor}) : trial[DVR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv <= dividend;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      dv <= {dv[DIV_W-2:0], 1'b0};
      rem <= rem_next;
      quotient <= {quotient[DIV_W-2:0], qbit};
    end
  end

endmodule

>>> rtl/pvsm_mult.sv
// shift-add multiplier, one multiplier bit per cycle, signed by unsigned
module pvsm_mult (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pvsm_pkg::MC_W-1:0]  mcand,
  input  logic        [pvsm_pkg::MQ_W-1:0]  mplier,
  output logic                              done,
  output logic signed [pvsm_pkg::PR_W-1:0]  prod
);
  import pvsm_pkg::*;

  localparam int CNT_W = $clog2(MQ_W + 1);

  logic signed [PR_W-1:0] mc_sh;
  logic        [MQ_W-1:0] mq;
  logic        [CNT_W-1:0] cnt;
  logic                    busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(MQ_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      mc_sh <= PR_W'(mcand);
      mq <= mplier;
    end else if (busy) begin
      if (mq[0]) begin
        prod <= prod + mc_sh;
      end
      mc_sh <= mc_sh <<< 1;
      mq <= mq >> 1;
    end
  end

endmodule

>>> rtl/pvsm_sine_rom.sv
// quarter-sine table in q1.15 with registered read
module pvsm_sine_rom #(
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic [$clog2(DEPTH + 1)-1:0]     addr,
  output logic [pvsm_pkg::ROM_W-1:0]       data
);
  import pvsm_pkg::*;

  logic [ROM_W-1:0] sine_tab [DEPTH + 1];

  for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_entry
    localparam longint XQ = (longint'(gi) * HALF_PI_Q30 + longint'(DEPTH / 2)) / DEPTH;
    localparam logic [ROM_W-1:0] VAL = sine_q15(XQ);
    assign sine_tab[gi] = VAL;
  end

  always_ff @(posedge clk) begin
    data <= sine_tab[addr];
  end

endmodule

>>> rtl/poly_voice_stereo_mixdown_core.sv
// top level of the equal-power pan stereo mixdown block
//
// voices of one frame arrive on the s_ stream, one item per voice; s_tlast marks the
// final voice. each voice is scaled by two gains and panned with cosine and sine from
// the quarter-sine table, then summed into left and right accumulators.
// on the final voice one item leaves on the m_ stream: the stereo pair, or the mono
// fold-down on the left and zero on the right. accumulators then clear.
// s_tready is high only in the idle state, so no voice is taken until the previous one is done:
// cv division, two table interpolations and four products, with the interpolations and
// products all on the single shift-add multiplier. the final voice adds the output step
// in stereo mode, and in mono mode a fold-down product before it; voices past MAX_VOICES
// in a frame are dropped.
// the result sits in an output register; the block keeps taking voices while it waits and
// stalls only when a new result is due and the old one is still not taken. the user must
// write registers through the apb port while the block is idle; the block does not enforce
// it. synchronous reset restores register defaults, clears accumulators and output valid.
module poly_voice_stereo_mixdown_core #(
  parameter int MAX_VOICES       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // audio_sample, level_a_cv, level_b_cv, pan_cv
  input  logic [pvsm_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // left_out, right_out
  output logic [pvsm_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import pvsm_pkg::*;

  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W = ANG_FRAC_W + IDX_W;

  state_t state;
  state_t state_next;
  mstep_t mstep;

  logic [10:0]             level_a_offset;
  logic [10:0]             level_b_offset;
  logic signed [11:0]      pan_offset;
  logic                    stereo_mode;

  logic signed [ACC_W-1:0] left_acc;
  logic signed [ACC_W-1:0] right_acc;
  logic [CNT_W-1:0]        voice_count;
  logic                    tsel;

  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic [GAIN_W-1:0]          gain_a;
  logic [GAIN_W-1:0]          gain_b;
  logic [ANG_W-1:0]           p_ang;
  logic [ROM_W-1:0]           rom_lo;
  logic [ROM_W-1:0]           rom_hi;
  logic [ROM_W-1:0]           trig_sn;
  logic [ROM_W-1:0]           trig_cs;
  logic signed [38:0]         voice_v;

  logic                 in_acc;
  logic                 count_ok;
  logic                 div_start;
  logic                 mul_start;
  logic                 out_load;
  logic                 da_done;
  logic                 db_done;
  logic                 dp_done;
  logic                 div_done;
  logic [DIV_W-1:0]     qa;
  logic [DIV_W-1:0]     qb;
  logic [DIV_W-1:0]     qp;
  logic                 mul_done;
  logic signed [MC_W-1:0] mul_mcand;
  logic [MQ_W-1:0]      mul_mplier;
  logic signed [PR_W-1:0] mul_prod;
  logic [IDX_W-1:0]     rom_addr;
  logic [ROM_W-1:0]     rom_data;

  logic [ANG_W-1:0]       ang;
  logic [POS_W-1:0]       pos;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       idx_hi;
  logic [ANG_FRAC_W-1:0]  frac;
  logic [ROM_W-1:0]       diff;
  logic [27:0]            interp_r;
  logic [ROM_W-1:0]       trig;
  logic signed [18:0]     ga_sum;
  logic signed [18:0]     gb_sum;
  logic signed [18:0]     pan_sum;
  logic [GAIN_W-1:0]      ga_clamp;
  logic [GAIN_W-1:0]      gb_clamp;
  logic [ANG_W-1:0]       p_clamp;
  logic signed [MC_W-1:0] mono_sum;
  logic signed [PR_W-1:0] term;
  logic [OUT_W-1:0]       left_res;
  logic [OUT_W-1:0]       right_res;
  logic                   cfg_wr;

  function automatic logic signed [PR_W-1:0] round_away(input logic signed [PR_W-1:0] x,
                                                        input int sh);
    logic [PR_W-1:0] mag;
    logic [PR_W-1:0] half;
    half = PR_W'(1) << (sh - 1);
    mag = x[PR_W-1] ? PR_W'(-x) : PR_W'(x);
    mag = (mag + half) >> sh;
    return x[PR_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [PR_W-1:0] t);
    logic signed [ACC_W:0] sum;
    sum = (ACC_W + 1)'(acc) + (ACC_W + 1)'(t);
    if (sum > (ACC_W + 1)'(ACC_MAX)) begin
      return ACC_W'(ACC_MAX);
    end else if (sum < (ACC_W + 1)'(ACC_MIN)) begin
      return ACC_W'(ACC_MIN);
    end
    return ACC_W'(sum);
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [PR_W-1:0] x);
    if (x > PR_W'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end else if (x < PR_W'(OUT_MIN)) begin
      return OUT_W'(OUT_MIN);
    end
    return x[OUT_W-1:0];
  endfunction

  pvsm_cvdiv u_div_a (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_W'($signed(s_tdata[31:16])) + DIV_W'(GAIN_PRE)),
    .divisor(DVR_W'(GAIN_DIV)), .done(da_done), .quotient(qa)
  );

  pvsm_cvdiv u_div_b (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_W'($signed(s_tdata[47:32])) + DIV_W'(GAIN_PRE)),
    .divisor(DVR_W'(GAIN_DIV)), .done(db_done), .quotient(qb)
  );

  pvsm_cvdiv u_div_p (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(DIV_W'($signed(s_tdata[63:48])) + DIV_W'(PAN_PRE)),
    .divisor(DVR_W'(PAN_DIV)), .done(dp_done), .quotient(qp)
  );

  pvsm_mult u_mult (
    .clk(clk), .rst(rst), .start(mul_start),
    .mcand(mul_mcand), .mplier(mul_mplier), .done(mul_done), .prod(mul_prod)
  );

  pvsm_sine_rom #(
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk(clk), .addr(rom_addr), .data(rom_data)
  );

  assign div_done = da_done & db_done & dp_done;
  assign count_ok = (voice_count < CNT_W'(MAX_VOICES));
  assign in_acc = s_tvalid & s_tready;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // gain and pan from knob plus cv term
  always_comb begin
    ga_sum = 19'(level_a_offset) + 19'(qa) - 19'(GAIN_POST);
    gb_sum = 19'(level_b_offset) + 19'(qb) - 19'(GAIN_POST);
    pan_sum = 19'(pan_offset) + 19'(qp) - 19'(PAN_POST);
    if (ga_sum < 0) begin
      ga_clamp = '0;
    end else if (ga_sum > 19'(GAIN_MAX)) begin
      ga_clamp = GAIN_W'(GAIN_MAX);
    end else begin
      ga_clamp = GAIN_W'(ga_sum);
    end
    if (gb_sum < 0) begin
      gb_clamp = '0;
    end else if (gb_sum > 19'(GAIN_MAX)) begin
      gb_clamp = GAIN_W'(GAIN_MAX);
    end else begin
      gb_clamp = GAIN_W'(gb_sum);
    end
    if (pan_sum < -19'(PAN_LIM)) begin
      p_clamp = '0;
    end else if (pan_sum > 19'(PAN_LIM)) begin
      p_clamp = ANG_W'(ANG_FULL);
    end else begin
      p_clamp = ANG_W'(pan_sum + 19'(PAN_LIM));
    end
  end

  // table position for sine or cosine, interpolation result, mono sum and rounded product term
  always_comb begin
    ang = tsel ? ANG_W'(ANG_W'(ANG_FULL) - p_ang) : p_ang;
    pos = POS_W'(ang) * POS_W'(SINE_TABLE_DEPTH);
    idx = pos[POS_W-1:ANG_FRAC_W];
    frac = pos[ANG_FRAC_W-1:0];
    idx_hi = (idx >= IDX_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH) : idx + IDX_W'(1);
    diff = rom_hi - rom_lo;
    interp_r = mul_prod[27:0] + 28'd1024;
    trig = ROM_W'(17'(rom_lo) + interp_r[27:11]);
    mono_sum = MC_W'(left_acc) + MC_W'(right_acc);
    term = round_away(mul_prod, 19);
  end

  always_comb begin
    mul_mcand = '0;
    mul_mplier = '0;
    case (mstep)
      M_INTERP: begin
        mul_mcand = MC_W'(diff);
        mul_mplier = MQ_W'(frac);
      end
      M_GAIN_A: begin
        mul_mcand = MC_W'(sample);
        mul_mplier = MQ_W'(gain_a);
      end
      M_GAIN_B: begin
        mul_mcand = MC_W'($signed(mul_prod[27:0]));
        mul_mplier = MQ_W'(gain_b);
      end
      M_COS: begin
        mul_mcand = MC_W'(voice_v);
        mul_mplier = trig_cs;
      end
      M_SIN: begin
        mul_mcand = MC_W'(voice_v);
        mul_mplier = trig_sn;
      end
      M_FOLD: begin
        mul_mcand = mono_sum;
        mul_mplier = MQ_W'(MONO_GAIN);
      end
      default: begin
        mul_mcand = '0;
        mul_mplier = '0;
      end
    endcase
  end

  always_comb begin
    if (stereo_mode) begin
      left_res = sat_out(round_away(PR_W'(left_acc), 16));
      right_res = sat_out(round_away(PR_W'(right_acc), 16));
    end else begin
      left_res = sat_out(round_away(mul_prod, 31));
      right_res = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (count_ok) begin
            state_next = S_DIV_WAIT;
          end else if (s_tlast) begin
            state_next = stereo_mode ? S_EMIT : S_MGO;
          end
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_RD_LO;
        end
      end
      S_RD_LO:   state_next = S_RD_HI;
      S_RD_HI:   state_next = S_RD_LAST;
      S_RD_LAST: state_next = S_MGO;
      S_MGO:     state_next = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          case (mstep)
            M_INTERP: state_next = tsel ? S_MGO : S_RD_LO;
            M_SIN: begin
              if (last) begin
                state_next = stereo_mode ? S_EMIT : S_MGO;
              end else begin
                state_next = S_IDLE;
              end
            end
            M_FOLD:  state_next = S_EMIT;
            default: state_next = S_MGO;
          endcase
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    div_start = s_tvalid && (state == S_IDLE) && count_ok;
    mul_start = (state == S_MGO);
    rom_addr = (state == S_RD_LO) ? idx : idx_hi;
    out_load = (state == S_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= M_INTERP;
      tsel <= 1'b0;
      voice_count <= '0;
      left_acc <= '0;
      right_acc <= '0;
      m_tvalid <= 1'b0;
      level_a_offset <= 11'd1024;
      level_b_offset <= 11'd1024;
      pan_offset <= '0;
      stereo_mode <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_LEVEL_A: level_a_offset <= pwdata[10:0];
          REG_LEVEL_B: level_b_offset <= pwdata[10:0];
          REG_PAN:     pan_offset <= pwdata[11:0];
          REG_MODE:    stereo_mode <= pwdata[0];
          default:     ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && !count_ok && s_tlast && !stereo_mode) begin
            mstep <= M_FOLD;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            tsel <= 1'b0;
            mstep <= M_INTERP;
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            case (mstep)
              M_INTERP: begin
                if (tsel) begin
                  mstep <= M_GAIN_A;
                end
                tsel <= 1'b1;
              end
              M_GAIN_A: mstep <= M_GAIN_B;
              M_GAIN_B: mstep <= M_COS;
              M_COS: begin
                left_acc <= sat_acc(left_acc, term);
                mstep <= M_SIN;
              end
              M_SIN: begin
                right_acc <= sat_acc(right_acc, term);
                voice_count <= voice_count + CNT_W'(1);
                if (last && !stereo_mode) begin
                  mstep <= M_FOLD;
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (out_load) begin
            left_acc <= '0;
            right_acc <= '0;
            voice_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= $signed(s_tdata[15:0]);
      last <= s_tlast;
    end
    if (state == S_DIV_WAIT && div_done) begin
      gain_a <= ga_clamp;
      gain_b <= gb_clamp;
      p_ang <= p_clamp;
    end
    if (state == S_RD_HI) begin
      rom_lo <= rom_data;
    end
    if (state == S_RD_LAST) begin
      rom_hi <= rom_data;
    end
    if (state == S_MWAIT && mul_done) begin
      if (mstep == M_INTERP) begin
        if (tsel) begin
          trig_cs <= trig;
        end else begin
          trig_sn <= trig;
        end
      end
      if (mstep == M_GAIN_B) begin
        voice_v <= mul_prod[38:0];
      end
    end
    if (out_load) begin
      m_tdata <= {right_res, left_res};
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEVEL_A: prdata = {21'b0, level_a_offset};
      REG_LEVEL_B: prdata = {21'b0, level_b_offset};
      REG_PAN:     prdata = {20'b0, pan_offset};
      REG_MODE:    prdata = {31'b0, stereo_mode};
      default:     prdata = '0;
    endcase
  end

endmodule

>>> verif/tb_top.sv
// self-checking testbench of the stereo mixdown core: voice streams, knob writes, pair checks
`timescale 1ns / 1ps

module tb_top;
  import pvsm_pkg::*;

  localparam int VOICE_LIMIT   = 16;
  localparam int SINE_DEPTH    = 256;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_VOICES  = 180;

  typedef struct packed {
    logic signed [OUT_W-1:0] right;
    logic signed [OUT_W-1:0] left;
  } stereo_mix_t;

  class stereo_mix_model;
    int unsigned sine_rom [0:SINE_DEPTH];
    logic [10:0] level_a;
    logic [10:0] level_b;
    logic signed [11:0] pan_knob;
    logic stereo;
    longint left_acc;
    longint right_acc;
    int unsigned voices_in_frame;
    stereo_mix_t pending_mixes[$];
    int unsigned mismatches;

    function new();
      longint x, x2, term, sum, q;
      int i, k;
      for (i = 0; i <= SINE_DEPTH; i++) begin
        x = (longint'(i) * HALF_PI_Q30 + SINE_DEPTH / 2) / SINE_DEPTH;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (k = 1; k <= 6; k++) begin
          term = ((term * x2) >>> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32768) begin
          q = 64'sd32768;
        end
        sine_rom[i] = int'(q);
      end
      level_a = 11'd1024;
      level_b = 11'd1024;
      pan_knob = 12'sd0;
      stereo = 1'b1;
      left_acc = 0;
      right_acc = 0;
      voices_in_frame = 0;
      mismatches = 0;
    endfunction

    function void set_register(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
        REG_LEVEL_A: level_a = value[10:0];
        REG_LEVEL_B: level_b = value[10:0];
        REG_PAN:     pan_knob = value[11:0];
        REG_MODE:    stereo = value[0];
        default: ;
      endcase
    endfunction

    function longint clamp_range(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) begin
        q = q - 1;
      end
      return q;
    endfunction

    function longint round_shift(input longint v, input int sh);
      longint m, r;
      m = (v < 0) ? -v : v;
      r = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -r : r;
    endfunction

    function longint quarter_sine(input longint p);
      longint pos, idx, frac, lo, hi;
      pos = p * SINE_DEPTH;
      idx = pos >>> ANG_FRAC_W;
      frac = pos & 64'sd2047;
      if (idx >= SINE_DEPTH) begin
        return longint'(sine_rom[SINE_DEPTH]);
      end
      lo = longint'(sine_rom[idx]);
      hi = longint'(sine_rom[idx + 1]);
      return lo + (((hi - lo) * frac + 64'sd1024) >>> ANG_FRAC_W);
    endfunction

    function void add_voice(input logic signed [15:0] smp, input logic signed [15:0] cva,
                            input logic signed [15:0] cvb, input logic signed [15:0] cvp,
                            input logic last);
      longint gain_a, gain_b, pan, angle, sin_q, cos_q, prod;
      stereo_mix_t mix;
      if (voices_in_frame < VOICE_LIMIT) begin
        gain_a = clamp_range(longint'(level_a) +
                             floor_div(longint'(cva) + GAIN_DIV / 2, GAIN_DIV), 0, GAIN_MAX);
        gain_b = clamp_range(longint'(level_b) +
                             floor_div(longint'(cvb) + GAIN_DIV / 2, GAIN_DIV), 0, GAIN_MAX);
        pan = clamp_range(longint'(pan_knob) +
                          floor_div(longint'(cvp) + PAN_DIV / 2, PAN_DIV), -PAN_LIM, PAN_LIM);
        angle = pan + PAN_LIM;
        sin_q = quarter_sine(angle);
        cos_q = quarter_sine(ANG_FULL - angle);
        prod = longint'(smp) * gain_a * gain_b;
        left_acc = clamp_range(left_acc + round_shift(prod * cos_q, 19), ACC_MIN, ACC_MAX);
        right_acc = clamp_range(right_acc + round_shift(prod * sin_q, 19), ACC_MIN, ACC_MAX);
        voices_in_frame++;
      end
      if (last) begin
        if (stereo) begin
          mix.left = OUT_W'(clamp_range(round_shift(left_acc, 16), OUT_MIN, OUT_MAX));
          mix.right = OUT_W'(clamp_range(round_shift(right_acc, 16), OUT_MIN, OUT_MAX));
        end else begin
          mix.left = OUT_W'(clamp_range(round_shift((left_acc + right_acc) *
                                                    longint'(MONO_GAIN), 31),
                                        OUT_MIN, OUT_MAX));
          mix.right = '0;
        end
        pending_mixes.insert(pending_mixes.size(), mix);
        left_acc = 0;
        right_acc = 0;
        voices_in_frame = 0;
      end
    endfunction

    function void check_mix(input logic [OUT_DATA_W-1:0] data);
      stereo_mix_t want;
      logic signed [OUT_W-1:0] got_left;
      logic signed [OUT_W-1:0] got_right;
      got_left = data[OUT_W-1:0];
      got_right = data[2*OUT_W-1:OUT_W];
      if (pending_mixes.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected item left %0d right %0d", $realtime, got_left, got_right);
        end
        mismatches++;
        return;
      end
      want = pending_mixes.pop_front();
      if (want.left !== got_left || want.right !== got_right) begin
        if (mismatches < 10) begin
          $display("%0t: left exp %0d got %0d, right exp %0d got %0d", $realtime,
                   want.left, got_left, want.right, got_right);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  stereo_mix_model mixer;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  poly_voice_stereo_mixdown_core #(
    .MAX_VOICES      (VOICE_LIMIT),
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    mixer.set_register(idx, value);
  endtask

  task automatic send_voice(input logic signed [15:0] smp, input logic signed [15:0] cva,
                            input logic signed [15:0] cvb, input logic signed [15:0] cvp,
                            input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cvp, cvb, cva, smp};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mixer.add_voice(smp, cva, cvb, cvp, last);
  endtask

  task automatic drain_frames();
    s_tvalid <= 1'b0;
    while (mixer.pending_mixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_level(input int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return 16'($urandom);
      4: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'(v);
    endcase
  endfunction

  task automatic program_knobs(input int phase);
    logic [10:0] a_val;
    logic [10:0] b_val;
    logic signed [11:0] pan_val;
    logic mode_val;
    a_val = 11'($urandom_range(1024));
    b_val = 11'($urandom_range(1024));
    pan_val = 12'(int'($urandom_range(2048)) - 1024);
    mode_val = 1'($urandom_range(1));
    case (phase)
      1: begin
        a_val = 11'd1024; b_val = 11'd1024; pan_val = 12'sd0; mode_val = 1'b1;
      end
      2: begin
        a_val = 11'd0; b_val = 11'd2047; pan_val = -12'sd2048; mode_val = 1'b1;
      end
      3: begin
        a_val = 11'd2047; b_val = 11'd2047; pan_val = 12'sd2047; mode_val = 1'b0;
      end
      5: begin
        a_val = 11'd1024; b_val = 11'd512; pan_val = 12'sd1024; mode_val = 1'b1;
      end
      7: begin
        a_val = 11'd300; b_val = 11'd1500; pan_val = -12'sd1024; mode_val = 1'b0;
      end
      default: ;
    endcase
    apb_write(REG_LEVEL_A, {21'd0, a_val});
    apb_write(REG_LEVEL_B, {21'd0, b_val});
    apb_write(REG_PAN, {20'd0, pan_val});
    apb_write(REG_MODE, {31'd0, mode_val});
  endtask

  task automatic random_frames(input int target);
    int sent;
    int len;
    int v;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      for (v = 0; v < len; v++) begin
        send_voice(pick_level(32767), pick_level(20480), pick_level(20480),
                   pick_level(10240), v == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        mixer.check_mix(m_tdata);
      end
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    #15000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase;
    int v;
    mixer = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gain and pan cv rounding edges in one frame
    send_voice(16'sd1000, -16'sd10, 16'sd9, -16'sd5, 1'b0);
    send_voice(-16'sd1000, -16'sd11, 16'sd10, -16'sd6, 1'b0);
    send_voice(16'sd20000, 16'sd10, -16'sd10, 16'sd4, 1'b0);
    send_voice(-16'sd20000, 16'sd9, -16'sd11, 16'sd5, 1'b1);
    send_voice(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_voice(16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_voice(16'sd0, 16'sh7fff, 16'sh7fff, 16'sd0, 1'b1);
    send_voice(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
    send_voice(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1);
    send_voice(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1);
    // one voice beyond the frame limit
    for (v = 0; v <= VOICE_LIMIT; v++) begin
      send_voice(16'sh8000, 16'sh7fff, 16'sh7fff, 16'(v * 1000 - 8000), v == VOICE_LIMIT);
    end
    drain_frames();

    for (phase = 1; phase <= 8; phase++) begin
      program_knobs(phase);
      case (phase % 4)
        1: begin
          sender_idle_pct = 0; receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 54; receiver_stall_pct = 0;
        end
        3: begin
          sender_idle_pct = 0; receiver_stall_pct = 54;
        end
        default: begin
          sender_idle_pct = 9; receiver_stall_pct = 9;
        end
      endcase
      random_frames(PHASE_VOICES);
      drain_frames();
    end

    if (mixer.mismatches == 0 && mixer.pending_mixes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> poly_voice_stereo_mixdown_core.f
rtl/pvsm_pkg.sv
rtl/pvsm_cvdiv.sv
rtl/pvsm_mult.sv
rtl/pvsm_sine_rom.sv
rtl/poly_voice_stereo_mixdown_core.sv
verif/tb_top.sv
